### rtl/lobt_pkg.sv
// package: shared types, sizes and codes for the limit order book table
`timescale 1ns / 1ps
package lobt_pkg;

    localparam int ORDER_SLOTS = 64;
    localparam int IDX_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int QTY_W = 23;
    localparam int PRICE_W = 20;
    localparam int ID_W = 32;
    localparam int TOTAL_W = 29;
    // sums are exact; never narrower than the reported totals
    localparam int SUM_W = (QTY_W + IDX_W > TOTAL_W) ? QTY_W + IDX_W : TOTAL_W;
    localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'({TOTAL_W{1'b1}});
    localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(ORDER_SLOTS);

    // operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_QTY   = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]             operation;
        logic [ID_W-1:0]        req_id;
        logic                   side;
        logic [PRICE_W-1:0]     price;
        logic signed [23:0]     quantity;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             status;
        logic                   found_side;
        logic [PRICE_W-1:0]     found_price;
        logic [QTY_W-1:0]       found_quantity;
        logic                   bid_present;
        logic [PRICE_W-1:0]     best_bid_price;
        logic                   ask_present;
        logic [PRICE_W-1:0]     best_ask_price;
        logic [TOTAL_W-1:0]     bid_total;
        logic [TOTAL_W-1:0]     ask_total;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic                   side;
        logic [PRICE_W-1:0]     price;
        logic [QTY_W-1:0]       qty;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_scan;
        logic scan_match;
        logic update;
        logic scan_best;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } t_dp_sts;

endpackage

### rtl/lobt_if.sv
// interfaces: valid/ready channels for request and result items
`timescale 1ns / 1ps
interface lobt_in_if;
    logic                  valid;
    logic                  ready;
    lobt_pkg::t_in_item    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lobt_out_if;
    logic                  valid;
    logic                  ready;
    lobt_pkg::t_out_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/lobt_datapath.sv
// datapath: order memory, valid bits, slot scans, sums and result register
`timescale 1ns / 1ps
module lobt_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lobt_pkg::t_dp_cmd   i_cmd,
    output lobt_pkg::t_dp_sts   o_sts,
    input  lobt_pkg::t_in_item  i_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lobt_pkg::t_out_item o_out_data
);
    import lobt_pkg::*;

    t_entry                r_mem [ORDER_SLOTS];
    logic [ORDER_SLOTS-1:0] r_valid;
    t_in_item              r_req;
    logic [CNT_W-1:0]      r_idx;
    logic                  r_pend;
    t_entry                r_rd;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_mslot;
    t_entry                r_mdata;
    logic                  r_free;
    logic [IDX_W-1:0]      r_fslot;
    logic [SUM_W-1:0]      r_buy_sum;
    logic [SUM_W-1:0]      r_sell_sum;
    logic [2:0]            r_status;
    logic                  r_f_side;
    logic [PRICE_W-1:0]    r_f_price;
    logic [QTY_W-1:0]      r_f_qty;
    logic                  r_bid_p;
    logic [PRICE_W-1:0]    r_bid_px;
    logic                  r_ask_p;
    logic [PRICE_W-1:0]    r_ask_px;
    logic                  r_out_vld;
    t_out_item             r_out;

    logic                  w_scan;
    logic                  w_rd_valid;
    logic                  w_qty_ok;
    logic [SUM_W-1:0]      w_qty_ext;
    logic [SUM_W-1:0]      w_mqty_ext;
    logic                  w_wr_en;

    assign w_scan     = i_cmd.scan_match | i_cmd.scan_best;
    assign w_rd_valid = r_pend & r_valid[r_rd_idx];
    assign w_qty_ok   = !r_req.quantity[23] && (r_req.quantity != 24'sd0);
    assign w_qty_ext  = SUM_W'(r_req.quantity[QTY_W-1:0]);
    assign w_mqty_ext = SUM_W'(r_mdata.qty);
    assign w_wr_en    = i_cmd.update && (r_req.operation == OP_ADD) && w_qty_ok
                        && !r_found && r_free;

    assign o_sts.scan_done = (r_idx == SLOT_COUNT) && !r_pend;
    assign o_sts.out_busy  = r_out_vld;
    assign o_out_valid     = r_out_vld;
    assign o_out_data      = r_out;

    // order memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_fslot] <= '{id: r_req.req_id, side: r_req.side,
                                price: r_req.price, qty: r_req.quantity[QTY_W-1:0]};
        end
        if (w_scan && r_idx != SLOT_COUNT) begin
            r_rd     <= r_mem[r_idx[IDX_W-1:0]];
            r_rd_idx <= r_idx[IDX_W-1:0];
        end
    end

    // request capture and found fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_item;
        end
        if (i_cmd.scan_match && w_rd_valid && !r_found && r_rd.id == r_req.req_id) begin
            r_mslot <= r_rd_idx;
            r_mdata <= r_rd;
        end
        if (i_cmd.scan_match && r_pend && !r_valid[r_rd_idx] && !r_free) begin
            r_fslot <= r_rd_idx;
        end
    end

    // scan control, valid bits and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_valid    <= '0;
            r_found    <= 1'b0;
            r_free     <= 1'b0;
            r_buy_sum  <= '0;
            r_sell_sum <= '0;
            r_status   <= ST_NOT_FOUND;
            r_f_side   <= 1'b0;
            r_f_price  <= '0;
            r_f_qty    <= '0;
            r_bid_p    <= 1'b0;
            r_bid_px   <= '0;
            r_ask_p    <= 1'b0;
            r_ask_px   <= '0;
        end else begin
            // slot counter and read pipeline
            if (i_cmd.clr_scan) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (w_scan) begin
                if (r_idx != SLOT_COUNT) begin
                    r_idx  <= r_idx + CNT_W'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            // id match and free slot search
            if (i_cmd.load) begin
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end else if (i_cmd.scan_match) begin
                if (w_rd_valid && r_rd.id == r_req.req_id) begin
                    r_found <= 1'b1;
                end
                if (r_pend && !r_valid[r_rd_idx]) begin
                    r_free <= 1'b1;
                end
            end
            // apply the operation
            if (i_cmd.update) begin
                r_bid_p   <= 1'b0;
                r_bid_px  <= '0;
                r_ask_p   <= 1'b0;
                r_ask_px  <= '0;
                r_f_side  <= 1'b0;
                r_f_price <= '0;
                r_f_qty   <= '0;
                priority if (r_req.operation == OP_ADD) begin
                    priority if (!w_qty_ok) begin
                        r_status <= ST_BAD_QTY;
                    end else if (r_found) begin
                        r_status <= ST_DUP;
                    end else if (!r_free) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status         <= ST_OK;
                        r_valid[r_fslot] <= 1'b1;
                        if (r_req.side) begin
                            r_sell_sum <= r_sell_sum + w_qty_ext;
                        end else begin
                            r_buy_sum <= r_buy_sum + w_qty_ext;
                        end
                    end
                end else if ((r_req.operation == OP_CANCEL || r_req.operation == OP_FIND)
                             && r_found) begin
                    r_status  <= ST_OK;
                    r_f_side  <= r_mdata.side;
                    r_f_price <= r_mdata.price;
                    r_f_qty   <= r_mdata.qty;
                    if (r_req.operation == OP_CANCEL) begin
                        r_valid[r_mslot] <= 1'b0;
                        if (r_mdata.side) begin
                            r_sell_sum <= r_sell_sum - w_mqty_ext;
                        end else begin
                            r_buy_sum <= r_buy_sum - w_mqty_ext;
                        end
                    end
                end else begin
                    r_status <= ST_NOT_FOUND;
                end
            end
            // best price search
            if (i_cmd.scan_best && w_rd_valid) begin
                if (!r_rd.side) begin
                    if (!r_bid_p || r_rd.price > r_bid_px) begin
                        r_bid_px <= r_rd.price;
                    end
                    r_bid_p <= 1'b1;
                end else begin
                    if (!r_ask_p || r_rd.price < r_ask_px) begin
                        r_ask_px <= r_rd.price;
                    end
                    r_ask_p <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out.status         <= r_status;
            r_out.found_side     <= r_f_side;
            r_out.found_price    <= r_f_price;
            r_out.found_quantity <= r_f_qty;
            r_out.bid_present    <= r_bid_p;
            r_out.best_bid_price <= r_bid_px;
            r_out.ask_present    <= r_ask_p;
            r_out.best_ask_price <= r_ask_px;
            r_out.bid_total      <= (r_buy_sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                            : r_buy_sum[TOTAL_W-1:0];
            r_out.ask_total      <= (r_sell_sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                             : r_sell_sum[TOTAL_W-1:0];
        end
    end

endmodule

### rtl/lobt_ctrl.sv
// controller: sequences the match scan, update, best price scan and result
`timescale 1ns / 1ps
module lobt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lobt_pkg::t_dp_sts i_sts,
    output lobt_pkg::t_dp_cmd o_cmd
);
    import lobt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE,
        S_BEST,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // commands decoded from state
    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = w_accept;
        o_cmd.clr_scan   = w_accept || (r_state == S_UPDATE);
        o_cmd.scan_match = (r_state == S_MATCH);
        o_cmd.update     = (r_state == S_UPDATE);
        o_cmd.scan_best  = (r_state == S_BEST);
        o_cmd.emit       = (r_state == S_EMIT) && !i_sts.out_busy;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_MATCH;
                end
                S_MATCH: begin
                    if (i_sts.scan_done) r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_state <= S_BEST;
                end
                S_BEST: begin
                    if (i_sts.scan_done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!i_sts.out_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy) else $error("result written over a pending one");
    a_match_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MATCH && i_sts.scan_done) |=> r_state == S_UPDATE)
        else $error("update did not follow match scan");
    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> !o_cmd.update) else $error("update issued twice");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == S_IDLE) else $error("no return to idle after emit");
`endif

endmodule

### rtl/limit_order_book_table.sv
// top level: limit order book table with controller and datapath
// sequence per request: an id match pass, an update, then a best price pass, both passes
// over the single read port of the order memory (id match, then best prices), then the result
// is written; a new request is accepted only once the previous result has been written, and
// that write waits while an earlier result is still held in the result register
// reset: synchronous active low; clears valid bits, sums and handshake state
`timescale 1ns / 1ps
module limit_order_book_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lobt_in_if.sink     i_in,
    lobt_out_if.source  o_out
);
    import lobt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lobt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lobt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_item      (i_in.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule

### tb/tb.sv
// testbench: limit order book table checked against an in-bench order table model
`timescale 1ns / 1ps
module tb;
    import lobt_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lobt_in_if  req_if ();
    lobt_out_if res_if ();

    limit_order_book_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source)
    );

    always #2 i_clk = ~i_clk;

    // book model state
    logic             bk_valid [ORDER_SLOTS] = '{default: 1'b0};
    logic [ID_W-1:0]  bk_id    [ORDER_SLOTS];
    logic             bk_side  [ORDER_SLOTS];
    logic [19:0]      bk_price [ORDER_SLOTS];
    logic [22:0]      bk_qty   [ORDER_SLOTS];
    longint unsigned  buy_qty_sum;
    longint unsigned  sell_qty_sum;

    t_out_item  pending_results [$];
    logic [ID_W-1:0] live_ids [$];
    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    function automatic int slot_of(input logic [ID_W-1:0] id);
        for (int k = 0; k < ORDER_SLOTS; k++)
            if (bk_valid[k] && bk_id[k] == id) return k;
        return -1;
    endfunction

    // compute the result of one request and update the book
    function automatic t_out_item book_apply(input t_in_item req);
        t_out_item r;
        int k;
        r = '0;
        r.status = ST_NOT_FOUND;
        if (req.operation == OP_ADD) begin
            if (req.quantity <= 0) begin
                r.status = ST_BAD_QTY;
            end else if (slot_of(req.req_id) >= 0) begin
                r.status = ST_DUP;
            end else begin
                k = -1;
                for (int j = ORDER_SLOTS - 1; j >= 0; j--)
                    if (!bk_valid[j]) k = j;
                if (k < 0) begin
                    r.status = ST_FULL;
                end else begin
                    bk_valid[k] = 1'b1;
                    bk_id[k] = req.req_id;
                    bk_side[k] = req.side;
                    bk_price[k] = req.price;
                    bk_qty[k] = req.quantity[22:0];
                    if (req.side) sell_qty_sum += req.quantity[22:0];
                    else buy_qty_sum += req.quantity[22:0];
                    live_ids.insert(live_ids.size(), req.req_id);
                    r.status = ST_OK;
                end
            end
        end else if (req.operation == OP_CANCEL || req.operation == OP_FIND) begin
            k = slot_of(req.req_id);
            if (k >= 0) begin
                r.status = ST_OK;
                r.found_side = bk_side[k];
                r.found_price = bk_price[k];
                r.found_quantity = bk_qty[k];
                if (req.operation == OP_CANCEL) begin
                    bk_valid[k] = 1'b0;
                    if (bk_side[k]) sell_qty_sum -= bk_qty[k];
                    else buy_qty_sum -= bk_qty[k];
                    foreach (live_ids[j])
                        if (live_ids[j] == req.req_id) begin
                            live_ids.delete(j);
                            break;
                        end
                end
            end
        end
        for (int j = 0; j < ORDER_SLOTS; j++) begin
            if (!bk_valid[j]) continue;
            if (!bk_side[j]) begin
                if (!r.bid_present || bk_price[j] > r.best_bid_price)
                    r.best_bid_price = bk_price[j];
                r.bid_present = 1'b1;
            end else begin
                if (!r.ask_present || bk_price[j] < r.best_ask_price)
                    r.best_ask_price = bk_price[j];
                r.ask_present = 1'b1;
            end
        end
        r.bid_total = (buy_qty_sum > 29'h1FFFFFFF) ? 29'h1FFFFFFF : buy_qty_sum[28:0];
        r.ask_total = (sell_qty_sum > 29'h1FFFFFFF) ? 29'h1FFFFFFF : sell_qty_sum[28:0];
        return r;
    endfunction

    // send one request; valid held until the transfer, returns at a falling edge
    task automatic send_request(input t_in_item req);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= req;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), book_apply(req));
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [31:0] id,
                               input logic sd, input logic [19:0] px,
                               input logic signed [23:0] q);
        t_in_item req;
        req.operation = op;
        req.req_id = id;
        req.side = sd;
        req.price = px;
        req.quantity = q;
        send_request(req);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %p", res_if.data);
            end else begin
                want = pending_results.pop_front();
                if (res_if.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch\n  expected %p\n  actual   %p",
                                 want, res_if.data);
                end
            end
        end
    end

    // drop valid after the last transfer, then wait for every result
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // boundaries, every operation and every status
    task automatic test_directed();
        send_fields(OP_FIND, 32'h0, 1'b0, 20'h0, 24'sd1);
        send_fields(OP_CANCEL, 32'hFFFFFFFF, 1'b1, 20'hFFFFF, 24'sd1);
        send_fields(OP_ADD, 32'h1, 1'b0, 20'h5, 24'sd0);
        send_fields(OP_ADD, 32'h1, 1'b0, 20'h5, -24'sd8388608);
        send_fields(OP_ADD, 32'h1, 1'b0, 20'h5, -24'sd1);
        send_fields(OP_ADD, 32'h0, 1'b0, 20'h0, 24'sd8388607);
        send_fields(OP_ADD, 32'hFFFFFFFF, 1'b1, 20'hFFFFF, 24'sd8388607);
        send_fields(OP_ADD, 32'hFFFFFFFF, 1'b0, 20'h1, 24'sd5);
        send_fields(OP_ADD, 32'h2, 1'b0, 20'hFFFFF, 24'sd1);
        send_fields(OP_ADD, 32'h3, 1'b1, 20'h0, 24'sd1);
        send_fields(OP_FIND, 32'hFFFFFFFF, 1'b0, 20'h0, 24'sd0);
        send_fields(2'd3, 32'h2, 1'b0, 20'h0, 24'sd0);
        send_fields(OP_CANCEL, 32'h2, 1'b0, 20'h0, 24'sd0);
        send_fields(OP_CANCEL, 32'h2, 1'b0, 20'h0, 24'sd0);
        // fill the table, overflow it, then free a middle slot
        for (int i = 0; i < ORDER_SLOTS; i++)
            send_fields(OP_ADD, 32'h100 + i, i[0], 20'(i * 7), 24'sd8388607);
        send_fields(OP_ADD, 32'h9999, 1'b0, 20'h10, 24'sd3);
        send_fields(OP_ADD, 32'h0, 1'b0, 20'h10, 24'sd3);
        send_fields(OP_CANCEL, 32'h3, 1'b0, 20'h0, 24'sd0);
        send_fields(OP_ADD, 32'h9999, 1'b1, 20'h10, 24'sd3);
        send_fields(OP_FIND, 32'h9999, 1'b0, 20'h0, 24'sd0);
        // empty the book
        while (live_ids.size() != 0)
            send_fields(OP_CANCEL, live_ids[0], 1'b0, 20'h0, 24'sd0);
        wait_drained();
    endtask

    // random mix aimed at live ids so cancels and finds mostly hit
    task automatic test_random(input int count, input int idle, input int stall);
        logic [1:0] op;
        logic [31:0] id;
        int pick;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = (pick < 45) ? OP_ADD : (pick < 70) ? OP_CANCEL :
                 (pick < 95) ? OP_FIND : 2'd3;
            if (live_ids.size() != 0 && $urandom_range(99) < 60)
                id = live_ids[$urandom_range(live_ids.size() - 1)];
            else if ($urandom_range(3) == 0)
                id = $urandom;
            else
                id = $urandom_range(80);
            send_fields(op, id, 1'($urandom_range(1)),
                        ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(64)),
                        ($urandom_range(9) == 0) ? 24'($urandom) :
                        24'($urandom_range(8388607, 1)));
        end
        wait_drained();
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(300, 0, 0);
        test_random(300, 84, 0);
        test_random(300, 0, 84);
        test_random(300, 38, 38);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2 * ORDER_SLOTS + 20) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
